// ===== sv/nbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbps_pkg
// Shared types, constants and helpers of the nearest boundary point search.
// ----------------------------------------------------------------------------
package nbps_pkg;

    // Fixed point format of q and a
    localparam int FRAC_BITS = 16;

    // Field widths
    localparam int Q_W     = 20;   // grid q, max_q
    localparam int PT_W    = 21;   // operating point coordinates
    localparam int A_W     = 17;   // boundary a
    localparam int D_W     = 22;   // signed coordinate differences
    localparam int DSQ_W   = 44;   // squared distance
    localparam int SQ_W    = 45;   // square root working width
    localparam int STEP_W  = 13;
    localparam int WIN_W   = 16;
    localparam int FSTEP_W = 9;
    localparam int P_W     = 16;   // powers of q
    localparam int QUO_W   = 14;   // linear segment quotient
    localparam int NUM_W   = 34;   // linear segment numerator
    localparam int CNT_W   = 5;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 104;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;

    // Segment limits of the boundary curve
    localparam int Q_LOW_LIM = (4 << FRAC_BITS) / 10;
    localparam int Q_MID_LIM = (706 << FRAC_BITS) / 1000;
    // Degree-8 series value at the upper segment limit
    localparam logic [QUO_W-1:0] A0 = QUO_W'(15530);

    // Iteration counts of the shared multi-cycle units
    localparam int DIV_ITERS  = QUO_W;
    localparam int SQRT_ITERS = DSQ_W / 2;
    localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (DSQ_W - 2);

    // Register reset values
    localparam logic [Q_W-1:0]     MAX_Q_RST      = Q_W'(59507);
    localparam logic [STEP_W-1:0]  GRID_PITCH_RST = STEP_W'(66);
    localparam logic [WIN_W-1:0]   FINE_SPAN_RST  = WIN_W'(655);
    localparam logic [FSTEP_W-1:0] FINE_PITCH_RST = FSTEP_W'(1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_Q      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_SPAN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FINE_PITCH = 2'd3;

    // Datapath commands
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_FINE_INIT,
        CMD_P2,
        CMD_P4,
        CMD_P6,
        CMD_P8,
        CMD_T6,
        CMD_T8,
        CMD_Q,
        CMD_SERIES,
        CMD_LINE_NUM,
        CMD_DIV_STEP,
        CMD_LINE_DONE,
        CMD_DQSQ,
        CMD_DASQ,
        CMD_CMP,
        CMD_SQRT_INIT,
        CMD_SQRT_STEP,
        CMD_PUBLISH
    } cmd_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EVAL,
        ST_P2,
        ST_P4,
        ST_P6,
        ST_P8,
        ST_T6,
        ST_T8,
        ST_Q,
        ST_SERIES,
        ST_LINE_NUM,
        ST_DIV,
        ST_LINE_DONE,
        ST_DQSQ,
        ST_DASQ,
        ST_CMP,
        ST_FINE_INIT,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_PUBLISH
    } state_t;

    // Datapath status
    typedef struct packed {
        logic is_line;    // grid point lies on the linear segment
        logic scan_end;   // next grid point would pass the window end
        logic out_busy;   // result register still held
    } status_t;

    // Floor division by 9 through a reciprocal, exact below 2^13
    function automatic logic [9:0] div9(input logic [12:0] n);
        logic [29:0] prod;
        prod = {17'd0, n} * 30'd116509;
        return prod[29:20];
    endfunction

endpackage
`default_nettype wire

// ===== sv/nearest_boundary_point_search_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_boundary_point_search_unit
// Nearest point on a piecewise boundary curve to an operating point.
// ----------------------------------------------------------------------------
// One request (point_q, point_a, signed Q4.16) yields one result. The unit
// scans a coarse grid from 0 to max_q, then a fine grid in a window of
// +/- fine_span around the coarse best, clipped to [0, max_q], and keeps the
// first grid point of least squared distance. A request is taken only while
// no search runs; a finished result waits in an output register and the next
// request is accepted while it waits. The sequencer walks each grid point one
// operation a cycle, through the power series on the series segments
// (q <= 0.706) and through a restoring divider that forms the line value on
// the linear segment; a search also takes the request, sets up the fine
// window, runs a bit-serial square root and publishes the result.
// ----------------------------------------------------------------------------
module nearest_boundary_point_search_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // point_q[20:0], point_a[41:21], zero pad [47:42]
    input  wire logic [nbps_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // nearest_q[19:0], nearest_a[36:20], vertical_dist[58:37],
    // horizontal_dist[79:59], euclid_dist[101:80], zero pad [103:102]
    output logic [nbps_pkg::M_TDATA_W-1:0]       m_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nbps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nbps_pkg::CFG_DAT_W-1:0]  cfg_data
);
    import nbps_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Register writes always taken
    assign cfg_ready = 1'b1;

    // Sequencer
    nbps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    nbps_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

// ===== sv/nbps_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbps_ctrl
// Sequencer of the search: steps each grid point through the boundary
// evaluation, distance and compare, then the square root and the result.
// ----------------------------------------------------------------------------
module nbps_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire nbps_pkg::status_t status,
    output nbps_pkg::cmd_t        cmd
);
    import nbps_pkg::*;

    state_t            state_reg, state_next;
    logic              fine_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // State and phase registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fine_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE)
                fine_reg <= 1'b0;
            else if (state_reg == ST_FINE_INIT)
                fine_reg <= 1'b1;
            if (state_reg == ST_DIV || state_reg == ST_SQRT)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else
                cnt_reg <= '0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_tvalid) state_next = ST_EVAL;
            ST_EVAL:      state_next = status.is_line ? ST_LINE_NUM : ST_P2;
            ST_P2:        state_next = ST_P4;
            ST_P4:        state_next = ST_P6;
            ST_P6:        state_next = ST_P8;
            ST_P8:        state_next = ST_T6;
            ST_T6:        state_next = ST_T8;
            ST_T8:        state_next = ST_Q;
            ST_Q:         state_next = ST_SERIES;
            ST_SERIES:    state_next = ST_DQSQ;
            ST_LINE_NUM:  state_next = ST_DIV;
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_ITERS - 1)) state_next = ST_LINE_DONE;
            end
            ST_LINE_DONE: state_next = ST_DQSQ;
            ST_DQSQ:      state_next = ST_DASQ;
            ST_DASQ:      state_next = ST_CMP;
            ST_CMP: begin
                if (!status.scan_end)
                    state_next = ST_EVAL;
                else if (!fine_reg)
                    state_next = ST_FINE_INIT;
                else
                    state_next = ST_SQRT_INIT;
            end
            ST_FINE_INIT: state_next = ST_EVAL;
            ST_SQRT_INIT: state_next = ST_SQRT;
            ST_SQRT: begin
                if (cnt_reg == CNT_W'(SQRT_ITERS - 1)) state_next = ST_PUBLISH;
            end
            ST_PUBLISH:   if (!status.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        cmd      = CMD_NONE;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd = CMD_LOAD;
            end
            ST_P2:        cmd = CMD_P2;
            ST_P4:        cmd = CMD_P4;
            ST_P6:        cmd = CMD_P6;
            ST_P8:        cmd = CMD_P8;
            ST_T6:        cmd = CMD_T6;
            ST_T8:        cmd = CMD_T8;
            ST_Q:         cmd = CMD_Q;
            ST_SERIES:    cmd = CMD_SERIES;
            ST_LINE_NUM:  cmd = CMD_LINE_NUM;
            ST_DIV:       cmd = CMD_DIV_STEP;
            ST_LINE_DONE: cmd = CMD_LINE_DONE;
            ST_DQSQ:      cmd = CMD_DQSQ;
            ST_DASQ:      cmd = CMD_DASQ;
            ST_CMP:       cmd = CMD_CMP;
            ST_FINE_INIT: cmd = CMD_FINE_INIT;
            ST_SQRT_INIT: cmd = CMD_SQRT_INIT;
            ST_SQRT:      cmd = CMD_SQRT_STEP;
            ST_PUBLISH:   if (!status.out_busy) cmd = CMD_PUBLISH;
            default:      cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== sv/nbps_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nbps_dp
// Datapath of the search: registers, boundary evaluation, line divider,
// squared distance, best-point tracking, square root and result register.
// ----------------------------------------------------------------------------
module nbps_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire nbps_pkg::cmd_t                cmd,
    output nbps_pkg::status_t                  status,
    input  wire logic [nbps_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [nbps_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                          cfg_valid,
    input  wire logic [nbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nbps_pkg::CFG_DAT_W-1:0] cfg_data
);
    import nbps_pkg::*;

    // Configuration
    logic [Q_W-1:0]     max_q_reg;
    logic [STEP_W-1:0]  grid_pitch_reg;
    logic [WIN_W-1:0]   fine_span_reg;
    logic [FSTEP_W-1:0] fine_pitch_reg;

    // Request and scan state
    logic signed [PT_W-1:0] pq_reg, pa_reg;
    logic [Q_W-1:0]     x_reg, hi_reg, bq_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               have_reg;
    logic [DSQ_W-1:0]   best_reg;
    logic [A_W-1:0]     ba_reg, ab_reg;

    // Boundary evaluation
    logic [P_W-1:0]     p2_reg, p4_reg, p6_reg, p8_reg;
    logic [12:0]        t6_reg;
    logic [11:0]        t8_reg;
    logic [9:0]         q6_reg, q8_reg;
    logic [NUM_W-1:0]   rem_reg, dsh_reg;
    logic [QUO_W-1:0]   quo_reg;

    // Distance and root
    logic [DSQ_W-1:0]   dqsq_reg, dasq_reg;
    logic [SQ_W-1:0]    sq_n_reg, sq_r_reg, sq_bit_reg;

    // Result
    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [STEP_W-1:0]  cs, fs;
    logic [Q_W:0]       x_adv;
    logic               is_mid;
    logic signed [D_W-1:0] dq_s, da_s, dqo_s, dao_s;
    logic signed [DSQ_W-1:0] dq_sq, da_sq;
    logic [DSQ_W-1:0]   dsq;
    logic [18:0]        p4x7;
    logic signed [17:0] sv;
    logic [Q_W-1:0]     diffq, denom, lo_q, hi_cl;
    logic [Q_W:0]       hi_sum;
    logic [SQ_W-1:0]    sq_trial;
    logic [PT_W-1:0]    hdist;

    // Zero steps count as one
    assign cs = (grid_pitch_reg == '0) ? STEP_W'(1) : grid_pitch_reg;
    assign fs = (fine_pitch_reg == '0) ? STEP_W'(1) : {4'd0, fine_pitch_reg};

    // Scan progress and segment decode
    assign x_adv  = {1'b0, x_reg} + {8'd0, step_reg};
    assign is_mid = x_reg > Q_W'(Q_LOW_LIM);
    assign status.is_line  = x_reg > Q_W'(Q_MID_LIM);
    assign status.scan_end = x_adv > {1'b0, hi_reg};
    assign status.out_busy = out_valid_reg && !m_tready;

    // Squared distance of the current candidate
    assign dq_s  = {pq_reg[PT_W-1], pq_reg} - $signed({2'b00, x_reg});
    assign da_s  = {pa_reg[PT_W-1], pa_reg} - $signed({5'd0, ab_reg});
    assign dq_sq = dq_s * dq_s;
    assign da_sq = da_s * da_s;
    assign dsq   = dqsq_reg + dasq_reg;

    // Series sum and clamp
    assign p4x7 = {p4_reg, 3'b000} - {3'b000, p4_reg};
    always_comb begin
        sv = $signed({3'b000, p2_reg[P_W-1:1]}) - $signed({6'd0, p4x7[18:7]});
        if (is_mid)
            sv = sv + $signed({8'd0, q6_reg}) - $signed({8'd0, q8_reg});
    end

    // Linear segment operands
    assign diffq = max_q_reg - x_reg;
    assign denom = max_q_reg - Q_W'(Q_MID_LIM);

    // Fine window bounds
    assign lo_q   = (bq_reg > {4'd0, fine_span_reg}) ? bq_reg - {4'd0, fine_span_reg}
                                                      : '0;
    assign hi_sum = {1'b0, bq_reg} + {5'd0, fine_span_reg};
    assign hi_cl  = (hi_sum > {1'b0, max_q_reg}) ? max_q_reg : hi_sum[Q_W-1:0];

    // Root trial and final differences
    assign sq_trial = sq_r_reg + sq_bit_reg;
    assign dqo_s = {pq_reg[PT_W-1], pq_reg} - $signed({2'b00, bq_reg});
    assign dao_s = $signed({5'd0, ba_reg}) - {pa_reg[PT_W-1], pa_reg};
    assign hdist = dqo_s[D_W-1] ? PT_W'(-dqo_s) : PT_W'(dqo_s);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_q_reg      <= MAX_Q_RST;
            grid_pitch_reg <= GRID_PITCH_RST;
            fine_span_reg  <= FINE_SPAN_RST;
            fine_pitch_reg <= FINE_PITCH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_Q:      max_q_reg      <= cfg_data[Q_W-1:0];
                REG_GRID_PITCH: grid_pitch_reg <= cfg_data[STEP_W-1:0];
                REG_FINE_SPAN:  fine_span_reg  <= cfg_data[WIN_W-1:0];
                REG_FINE_PITCH: fine_pitch_reg <= cfg_data[FSTEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn)
            out_valid_reg <= 1'b0;
        else if (cmd == CMD_PUBLISH)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Datapath registers, one operation per command
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_LOAD: begin
                pq_reg   <= s_tdata[PT_W-1:0];
                pa_reg   <= s_tdata[2*PT_W-1:PT_W];
                x_reg    <= '0;
                hi_reg   <= max_q_reg;
                step_reg <= cs;
                have_reg <= 1'b0;
            end
            CMD_FINE_INIT: begin
                x_reg    <= lo_q;
                hi_reg   <= hi_cl;
                step_reg <= fs;
                have_reg <= 1'b0;
            end
            CMD_P2: p2_reg <= P_W'(({16'd0, x_reg[P_W-1:0]} * {16'd0, x_reg[P_W-1:0]})
                                   >> FRAC_BITS);
            CMD_P4: p4_reg <= P_W'(({16'd0, p2_reg} * {16'd0, p2_reg}) >> FRAC_BITS);
            CMD_P6: p6_reg <= P_W'(({16'd0, p4_reg} * {16'd0, p2_reg}) >> FRAC_BITS);
            CMD_P8: p8_reg <= P_W'(({16'd0, p4_reg} * {16'd0, p4_reg}) >> FRAC_BITS);
            CMD_T6: t6_reg <= 13'(({5'd0, p6_reg} * 21'd29) >> 8);
            CMD_T8: t8_reg <= 12'(({17'd0, p8_reg} * 33'd68687) >> 21);
            CMD_Q: begin
                q6_reg <= div9(t6_reg);
                q8_reg <= div9({1'b0, t8_reg});
            end
            CMD_SERIES: ab_reg <= sv[17] ? '0 : sv[A_W-1:0];
            CMD_LINE_NUM: begin
                rem_reg <= {20'd0, A0} * {14'd0, diffq};
                dsh_reg <= {1'b0, denom, 13'd0};
                quo_reg <= '0;
            end
            CMD_DIV_STEP: begin
                if (rem_reg >= dsh_reg) begin
                    rem_reg <= rem_reg - dsh_reg;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            CMD_LINE_DONE: ab_reg <= {3'd0, quo_reg};
            CMD_DQSQ: dqsq_reg <= $unsigned(dq_sq);
            CMD_DASQ: dasq_reg <= $unsigned(da_sq);
            CMD_CMP: begin
                // strict compare keeps the first minimum
                if (!have_reg || dsq < best_reg) begin
                    best_reg <= dsq;
                    bq_reg   <= x_reg;
                    ba_reg   <= ab_reg;
                end
                have_reg <= 1'b1;
                x_reg    <= x_adv[Q_W-1:0];
            end
            CMD_SQRT_INIT: begin
                sq_n_reg   <= {1'b0, best_reg};
                sq_r_reg   <= '0;
                sq_bit_reg <= SQRT_BIT0;
            end
            CMD_SQRT_STEP: begin
                if (sq_n_reg >= sq_trial) begin
                    sq_n_reg <= sq_n_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            CMD_PUBLISH: begin
                out_data_reg <= {2'b00, sq_r_reg[D_W-1:0], hdist, dao_s,
                                 ba_reg, bq_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ===== tb/nearest_boundary_point_search_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nearest_boundary_point_search_unit_tb
// Streams operating points through the search unit under several register
// settings, predicts each nearest boundary point and checks every result.
// ----------------------------------------------------------------------------
// Each phase but the first writes the four registers, then sends directed
// points, random points or both, with random gaps on both sides. A scoreboard
// object keeps its own copy of the registers, predicts the grid search for
// every accepted request and compares each result field by field in order.
// ----------------------------------------------------------------------------

// Expected nearest point and distances of one request
typedef struct {
    logic [19:0] near_q;
    logic [16:0] near_a;
    logic [21:0] vert_d;
    logic [20:0] horz_d;
    logic [21:0] eucl_d;
} nearest_hit_t;

class nearest_point_board;
    longint unsigned max_q, grid_pitch, fine_span, fine_pitch;
    nearest_hit_t    pending_hits[$];
    int              errors;

    function new();
        max_q      = 59507;
        grid_pitch = 66;
        fine_span  = 655;
        fine_pitch = 1;
        errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [19:0] val);
        case (idx)
            nbps_pkg::REG_MAX_Q:      max_q      = val;
            nbps_pkg::REG_GRID_PITCH: grid_pitch = val[12:0];
            nbps_pkg::REG_FINE_SPAN:  fine_span  = val[15:0];
            nbps_pkg::REG_FINE_PITCH: fine_pitch = val[8:0];
            default: ;
        endcase
    endfunction

    // Truncated power series, clamped at zero
    function longint series_a(longint unsigned x, bit deg8);
        longint unsigned p2, p4, p6, p8;
        longint v;
        p2 = (x * x) >> nbps_pkg::FRAC_BITS;
        p4 = (p2 * p2) >> nbps_pkg::FRAC_BITS;
        v  = longint'(p2 >> 1) - longint'((7 * p4) >> 7);
        if (deg8) begin
            p6 = (p4 * p2) >> nbps_pkg::FRAC_BITS;
            p8 = (p4 * p4) >> nbps_pkg::FRAC_BITS;
            v += longint'((29 * p6) / 2304);
            v -= longint'((68687 * p8) / 18874368);
        end
        return (v < 0) ? 0 : v;
    endfunction

    function longint curve_a(longint unsigned x);
        longint unsigned a0, lim;
        lim = nbps_pkg::Q_MID_LIM;
        if (x <= nbps_pkg::Q_LOW_LIM) return series_a(x, 0);
        if (x <= lim) return series_a(x, 1);
        if (x <= max_q) begin
            a0 = series_a(lim, 1);
            return longint'((a0 * (max_q - x)) / (max_q - lim));
        end
        return 0;
    endfunction

    function longint unsigned dist_sq(longint pq, longint pa, longint unsigned x, longint ab);
        longint dq, da;
        dq = pq - longint'(x);
        da = pa - ab;
        return longint'(dq * dq) + longint'(da * da);
    endfunction

    function longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // First grid point of least squared distance in [lo, hi]
    function void grid_scan(longint pq, longint pa, longint unsigned lo, longint unsigned hi,
                            longint unsigned step, inout longint unsigned bq, inout longint ba);
        bit have;
        longint unsigned best, d, x;
        longint ab;
        have = 0;
        best = 0;
        for (x = lo; x <= hi; x += step) begin
            ab = curve_a(x);
            d  = dist_sq(pq, pa, x, ab);
            if (!have || d < best) begin
                have = 1;
                best = d;
                bq   = x;
                ba   = ab;
            end
        end
    endfunction

    function void note_request(logic [20:0] q_in, logic [20:0] a_in);
        longint pq, pa, ba, dq;
        longint unsigned cs, fs, bq, lo, hi;
        nearest_hit_t h;
        pq = longint'($signed(q_in));
        pa = longint'($signed(a_in));
        cs = grid_pitch ? grid_pitch : 1;
        fs = fine_pitch ? fine_pitch : 1;
        bq = 0;
        ba = 0;
        grid_scan(pq, pa, 0, max_q, cs, bq, ba);
        lo = (bq > fine_span) ? bq - fine_span : 0;
        hi = bq + fine_span;
        if (hi > max_q) hi = max_q;
        grid_scan(pq, pa, lo, hi, fs, bq, ba);
        dq = longint'(bq) - pq;
        h.near_q = bq[19:0];
        h.near_a = ba[16:0];
        h.vert_d = 22'(ba - pa);
        h.horz_d = 21'((dq < 0) ? -dq : dq);
        h.eucl_d = 22'(floor_sqrt(dist_sq(pq, pa, bq, ba)));
        pending_hits.push_back(h);
    endfunction

    function void check_result(logic [103:0] d);
        nearest_hit_t h;
        if (pending_hits.size() == 0) begin
            $error("result with no request outstanding: %h", d);
            errors++;
            return;
        end
        h = pending_hits.pop_front();
        if (d[19:0] !== h.near_q) begin
            $error("nearest_q expected %0d got %0d", h.near_q, d[19:0]);
            errors++;
        end
        if (d[36:20] !== h.near_a) begin
            $error("nearest_a expected %0d got %0d", h.near_a, d[36:20]);
            errors++;
        end
        if (d[58:37] !== h.vert_d) begin
            $error("vertical_dist expected %0d got %0d", $signed(h.vert_d),
                   $signed(d[58:37]));
            errors++;
        end
        if (d[79:59] !== h.horz_d) begin
            $error("horizontal_dist expected %0d got %0d", h.horz_d, d[79:59]);
            errors++;
        end
        if (d[101:80] !== h.eucl_d) begin
            $error("euclid_dist expected %0d got %0d", h.eucl_d, d[101:80]);
            errors++;
        end
    endfunction
endclass

module nearest_boundary_point_search_unit_tb;
    import nbps_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;

    nearest_point_board board;
    bit                 idle_free;      // no gaps on either side
    int                 hold_cycles;    // long receiver hold-off request

    always #6 aclk = ~aclk;

    nearest_boundary_point_search_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (idle_free || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    // Receiver: random back-pressure, checks at each accepted result
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                gap = gap_len();
            end
        end
    end

    // Valid stays high across a burst of writes; write_all drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
    endtask

    task automatic write_all(logic [19:0] mq, logic [19:0] cs, logic [19:0] fw,
                             logic [19:0] fs);
        write_reg(REG_MAX_Q, mq);
        write_reg(REG_GRID_PITCH, cs);
        write_reg(REG_FINE_SPAN, fw);
        write_reg(REG_FINE_PITCH, fs);
        cfg_valid <= 1'b0;
    endtask

    // One request; valid stays high across back-to-back requests
    task automatic send_point(logic [20:0] q, logic [20:0] a);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, a, q};
        do @(posedge aclk); while (!s_tready);
        board.note_request(q, a);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending_hits.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Points near the curve, with some full-range noise
    task automatic send_random(int n);
        int i;
        logic [20:0] q, a;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                q = 21'($urandom);
                a = 21'($urandom);
            end else begin
                q = 21'(int'($urandom_range(0, board.max_q + 4000)) - 2000);
                a = 21'(int'($urandom_range(0, 24000)) - 4000);
            end
            send_point(q, a);
        end
    endtask

    task automatic send_extremes();
        send_point(21'd0, 21'd0);
        send_point(21'h100000, 21'h100000);
        send_point(21'h0FFFFF, 21'h0FFFFF);
        send_point(21'h100000, 21'h0FFFFF);
        send_point(21'h0FFFFF, 21'h100000);
        send_point(21'(Q_LOW_LIM), 21'd2000);
        send_point(21'(Q_MID_LIM), 21'd15530);
        send_point(21'(board.max_q), 21'd0);
        send_point(21'h1FFFFF, 21'h1FFFFF);
    endtask

    initial begin
        board = new();
        idle_free = 0;
        hold_cycles = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, two requests only since each scan is long
        send_point(21'd30000, 21'd8000);
        send_point(21'd0, 21'h1FF000);
        wait_drained();

        // Coarse reset-like curve, cheap grid
        write_all(20'd59507, 20'd1024, 20'd64, 20'd8);
        send_extremes();
        send_point(21'd46269, 21'd15529);
        send_point(21'd50000, 21'd4000);
        idle_free = 1;
        send_random(30);
        idle_free = 0;
        send_random(40);
        wait_drained();

        // Widest ranges: full max_q and window, large steps
        write_all(20'hFFFFF, 20'd4096, 20'd65535, 20'd256);
        send_extremes();
        wait_drained();

        // Degenerate grid: single point, zero steps, receiver holds off
        write_all(20'd0, 20'd0, 20'd0, 20'd0);
        hold_cycles = 3000;
        send_extremes();
        send_random(25);
        wait_drained();

        // Curve ends inside the series part, steps at their largest values
        write_all(20'd30000, 20'd8191, 20'd300, 20'd511);
        send_extremes();
        send_random(20);
        wait_drained();

        // Unit steps over a short curve, window wider than the curve
        write_all(20'd200, 20'd1, 20'd65535, 20'd1);
        send_point(21'd100, 21'd0);
        send_point(21'h100000, 21'd50);
        send_random(8);
        wait_drained();

        // Short linear segment just past the series limit
        write_all(20'd47000, 20'd500, 20'd1000, 20'd17);
        send_extremes();
        send_random(15);
        wait_drained();
        send_random(25);
        wait_drained();

        if (board.errors == 0 && board.pending_hits.size() == 0) begin
            $display("nearest_boundary_point_search_unit: match");
        end else begin
            $display("nearest_boundary_point_search_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("nearest_boundary_point_search_unit: mismatch");
        $finish;
    end
endmodule
